// File: hw/rtl/cbspe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbspe_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int U_W        = FRAC_BITS + 1;
    localparam int CNT_W      = 7;
    localparam int DEGREE     = 3;
    localparam logic [U_W-1:0] ONE_Q = U_W'(1) << FRAC_BITS;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAN,
        S_READ,
        S_KNOT,
        S_KWAIT,
        S_ALPHA,
        S_AWAIT,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       take;
        logic       span;
        logic       rd_en;
        logic       rd_cap;
        logic       knot_start;
        logic       knot_store;
        logic       alpha_start;
        logic       alpha_store;
        logic       mul;
        logic       add;
        logic       finish;
        logic [2:0] cnt;
        logic [1:0] j;
        logic [1:0] round;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic ok;
        logic knot_triv;
        logic alpha_triv;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: hw/rtl/cbspe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cbspe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hw/rtl/cbspe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Radix-2 restoring divider: quotient = floor(num * 2^FRAC_BITS / den), num < den.
module cbspe_div
    import cbspe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [FRAC_BITS-1:0] i_num,
    input  wire logic [U_W-1:0]       i_den,
    output logic                      o_done,
    output logic      [FRAC_BITS-1:0] o_quo
);

    localparam int STEP_W = $clog2(FRAC_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [U_W-1:0]       r_rem;
    logic [U_W-1:0]       r_den;
    logic [FRAC_BITS-1:0] r_quo;
    logic [U_W:0]         n_shift;
    logic                 n_ge;

    assign n_shift = {r_rem, 1'b0};
    assign n_ge    = n_shift >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? U_W'(n_shift - {1'b0, r_den}) : U_W'(n_shift);
            r_quo <= {r_quo[FRAC_BITS-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// File: hw/rtl/cbspe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cbspe_ctrl
    import cbspe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_op,
    input  wire t_dp_stat i_stat,
    output logic          o_in_stall,
    output t_dp_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_j, n_j;
    logic [1:0] r_round, n_round;
    logic       w_take;

    assign o_in_stall = !(r_state == S_IDLE && i_stat.out_free);
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_j     <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_j     <= n_j;
            r_round <= n_round;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_j     = r_j;
        n_round = r_round;
        o_cmd   = '0;
        o_cmd.take  = w_take;
        o_cmd.cnt   = r_cnt;
        o_cmd.j     = r_j;
        o_cmd.round = r_round;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && i_op == OP_EVAL && i_stat.ok) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_cnt      = '0;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.rd_en  = r_cnt != 3'd4;
                o_cmd.rd_cap = r_cnt != 3'd0;
                if (r_cnt == 3'd4) begin
                    n_cnt   = '0;
                    n_state = S_KNOT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_KNOT: begin
                o_cmd.knot_start = 1'b1;
                if (!i_stat.knot_triv) begin
                    n_state = S_KWAIT;
                end else if (r_cnt == 3'd5) begin
                    n_round = 2'd1;
                    n_j     = 2'd3;
                    n_state = S_ALPHA;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_KWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.knot_store = 1'b1;
                    if (r_cnt == 3'd5) begin
                        n_round = 2'd1;
                        n_j     = 2'd3;
                        n_state = S_ALPHA;
                    end else begin
                        n_cnt   = r_cnt + 3'd1;
                        n_state = S_KNOT;
                    end
                end
            end
            S_ALPHA: begin
                o_cmd.alpha_start = 1'b1;
                n_state = i_stat.alpha_triv ? S_MUL : S_AWAIT;
            end
            S_AWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.alpha_store = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_j == r_round) begin
                    if (r_round == 2'd3) begin
                        n_state = S_DONE;
                    end else begin
                        n_round = r_round + 2'd1;
                        n_j     = 2'd3;
                        n_state = S_ALPHA;
                    end
                end else begin
                    n_j     = r_j - 2'd1;
                    n_state = S_ALPHA;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/cbspe_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module cbspe_dp
    import cbspe_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_cmd,
    output t_dp_stat                       o_stat,
    input  wire logic                      i_cfg_we,
    input  wire logic [CNT_W-1:0]          i_cfg_count,
    input  wire logic                      i_op,
    input  wire logic [ADDR_W-1:0]         i_index,
    input  wire logic signed [COORD_W-1:0] i_x,
    input  wire logic signed [COORD_W-1:0] i_y,
    input  wire logic [U_W-1:0]            i_u,
    input  wire logic                      i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_is_point,
    output logic                           o_ok,
    output logic signed [COORD_W-1:0]      o_x,
    output logic signed [COORD_W-1:0]      o_y
);

    localparam int PROD_W = COORD_W + 1 + U_W + 1;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          w_n;
    logic [CNT_W-1:0]          w_m;
    logic                      w_ok;
    logic [U_W-1:0]            r_u;
    logic [ADDR_W-1:0]         r_span;
    logic [U_W-1:0]            r_knot [6];
    logic signed [COORD_W-1:0] r_wx [4];
    logic signed [COORD_W-1:0] r_wy [4];
    logic [U_W-1:0]            r_alpha;
    logic signed [PROD_W-1:0]  r_px, r_py;

    // configuration and clamped count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_count;
        end
    end
    assign w_n  = (r_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_count;
    assign w_ok = w_n >= CNT_W'(DEGREE + 1);
    assign w_m  = w_n - CNT_W'(DEGREE);

    // span: 3 + floor(((u + 1) * m - 1) / 2^F), last span for u >= 1
    logic [U_W+CNT_W-1:0] w_sprod;
    logic [U_W+CNT_W-1:0] w_sq;
    assign w_sprod = (U_W+CNT_W)'(r_u + U_W'(1)) * (U_W+CNT_W)'(w_m);
    assign w_sq    = (w_sprod - (U_W+CNT_W)'(1)) >> FRAC_BITS;

    // control point store
    logic [2*COORD_W-1:0] w_rdata;
    logic [ADDR_W-1:0]    w_raddr;
    assign w_raddr = ADDR_W'(CNT_W'(r_span) - CNT_W'(DEGREE) + CNT_W'(i_cmd.cnt));

    cbspe_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && i_op == OP_LOAD),
        .i_waddr (i_index),
        .i_wdata ({i_x, i_y}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // knot for index span - 2 + cnt
    logic [CNT_W:0] w_kidx;
    logic           w_klow;
    assign w_kidx         = (CNT_W+1)'(r_span) - (CNT_W+1)'(2) + (CNT_W+1)'(i_cmd.cnt);
    assign w_klow         = w_kidx <= (CNT_W+1)'(DEGREE);
    assign o_stat.knot_triv = w_klow || w_kidx >= {1'b0, w_n};

    // alpha operands: k0 = knot[j - 1], k1 = knot[j + 3 - round]
    logic [2:0]           w_i0, w_i1;
    logic signed [U_W:0]  w_num, w_gap;
    logic                 w_azero, w_aone;
    assign w_i0    = 3'(i_cmd.j) - 3'd1;
    assign w_i1    = 3'(i_cmd.j) + 3'd3 - 3'(i_cmd.round);
    assign w_num   = $signed({1'b0, r_u}) - $signed({1'b0, r_knot[w_i0]});
    assign w_gap   = $signed({1'b0, r_knot[w_i1]}) - $signed({1'b0, r_knot[w_i0]});
    assign w_azero = w_gap <= 0 || w_num <= 0;
    assign w_aone  = !w_azero && w_num >= w_gap;
    assign o_stat.alpha_triv = w_azero || w_aone;

    // shared divider
    logic                 w_div_start;
    logic [FRAC_BITS-1:0] w_div_num;
    logic [U_W-1:0]       w_div_den;
    logic [FRAC_BITS-1:0] w_quo;
    assign w_div_start = (i_cmd.knot_start && !o_stat.knot_triv)
                      || (i_cmd.alpha_start && !o_stat.alpha_triv);
    assign w_div_num   = i_cmd.knot_start
                       ? FRAC_BITS'(w_kidx - (CNT_W+1)'(DEGREE))
                       : w_num[FRAC_BITS-1:0];
    assign w_div_den   = i_cmd.knot_start ? U_W'(w_m) : w_gap[U_W-1:0];

    cbspe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (o_stat.div_done),
        .o_quo   (w_quo)
    );

    // blend operands
    logic [1:0]                 w_jm1;
    logic [1:0]                 w_cap;
    logic signed [COORD_W:0]    w_dx, w_dy;
    logic signed [U_W:0]        w_as;
    assign w_jm1 = i_cmd.j - 2'd1;
    assign w_cap = 2'(i_cmd.cnt - 3'd1);
    assign w_dx  = $signed({r_wx[i_cmd.j][COORD_W-1], r_wx[i_cmd.j]})
                 - $signed({r_wx[w_jm1][COORD_W-1], r_wx[w_jm1]});
    assign w_dy  = $signed({r_wy[i_cmd.j][COORD_W-1], r_wy[i_cmd.j]})
                 - $signed({r_wy[w_jm1][COORD_W-1], r_wy[w_jm1]});
    assign w_as  = $signed({1'b0, r_alpha});

    // evaluation registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_u <= i_u;
        end
        if (i_cmd.span) begin
            r_span <= (r_u >= ONE_Q) ? ADDR_W'(w_n - CNT_W'(1))
                                     : ADDR_W'(w_sq + (U_W+CNT_W)'(DEGREE));
        end
        if (i_cmd.rd_cap) begin
            r_wx[w_cap] <= w_rdata[2*COORD_W-1:COORD_W];
            r_wy[w_cap] <= w_rdata[COORD_W-1:0];
        end
        if (i_cmd.knot_start && o_stat.knot_triv) begin
            r_knot[i_cmd.cnt] <= w_klow ? '0 : ONE_Q;
        end
        if (i_cmd.knot_store) begin
            r_knot[i_cmd.cnt] <= U_W'(w_quo);
        end
        if (i_cmd.alpha_start && o_stat.alpha_triv) begin
            r_alpha <= w_aone ? ONE_Q : '0;
        end
        if (i_cmd.alpha_store) begin
            r_alpha <= U_W'(w_quo);
        end
        if (i_cmd.mul) begin
            r_px <= PROD_W'(w_dx * w_as);
            r_py <= PROD_W'(w_dy * w_as);
        end
        if (i_cmd.add) begin
            r_wx[i_cmd.j] <= r_wx[w_jm1] + r_px[FRAC_BITS+COORD_W-1:FRAC_BITS];
            r_wy[i_cmd.j] <= r_wy[w_jm1] + r_py[FRAC_BITS+COORD_W-1:FRAC_BITS];
        end
    end

    // output register
    logic r_out_valid;
    logic r_is_point, r_ok;
    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic w_quick;
    assign w_quick = i_cmd.take && (i_op == OP_LOAD || !w_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_quick || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_quick) begin
            r_is_point <= i_op == OP_EVAL;
            r_ok       <= w_ok;
            r_ox       <= '0;
            r_oy       <= '0;
        end else if (i_cmd.finish) begin
            r_is_point <= 1'b1;
            r_ok       <= 1'b1;
            r_ox       <= r_wx[DEGREE];
            r_oy       <= r_wy[DEGREE];
        end
    end

    assign o_stat.ok       = w_ok;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_is_point      = r_is_point;
    assign o_ok            = r_ok;
    assign o_x             = r_ox;
    assign o_y             = r_oy;

endmodule
`default_nettype wire

// File: hw/rtl/cubic_bspline_point_evaluator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Loads, and evaluations with fewer than four points, reach the output register at the
// accepting edge and can follow every cycle while the output is not stalled. A full
// evaluation finds the span, fetches four points, forms six knots, runs six blends and
// hands off; each of up to 12 quotients comes from the shared 16-step divider. One item is
// in work at a time, and a result waiting at the output stalls the next item. Synchronous
// active-low reset clears point_count, control and output valid; the store is not cleared.
module cubic_bspline_point_evaluator_core
    import cbspe_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CNT_W-1:0]          i_cfg_point_count,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_operation,
    input  wire logic [ADDR_W-1:0]         i_point_index,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    input  wire logic [U_W-1:0]            i_param_u,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_is_point,
    output logic                           o_ok,
    output logic signed [COORD_W-1:0]      o_curve_x,
    output logic signed [COORD_W-1:0]      o_curve_y
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    cbspe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_operation),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    cbspe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_count (i_cfg_point_count),
        .i_op        (i_operation),
        .i_index     (i_point_index),
        .i_x         (i_point_x),
        .i_y         (i_point_y),
        .i_u         (i_param_u),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_is_point  (o_is_point),
        .o_ok        (o_ok),
        .o_x         (o_curve_x),
        .o_y         (o_curve_y)
    );

endmodule
`default_nettype wire
